// ===== rtl/rof_pkg.sv =====
// package: shared types, codes and defaults for the radius outlier filter
`timescale 1ns / 1ps

package rof_pkg;

  // default store depth
  localparam int MAX_POINTS_DEF = 1024;

  // field widths fixed by the interface
  localparam int COORD_W = 16;
  localparam int INDEX_W = 10;
  localparam int NBCNT_W = 11;
  localparam int RADIUS_W = 16;
  localparam int STATUS_W = 3;
  localparam int FUNC_W = 2;
  localparam int SQ_W = 2 * COORD_W;
  localparam int DIST_W = SQ_W + 2;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EVAL = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EVALUATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

  // register indexes and reset values
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_MIN_NB = 1'b1;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd200;
  localparam logic [NBCNT_W-1:0] MIN_NB_RST = 11'd3;
  localparam logic [NBCNT_W-1:0] NBCNT_SAT = 11'h7FF;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    point_t              pt;
    logic [NBCNT_W-1:0]  count;
    logic                keep;
  } result_t;

endpackage

// ===== rtl/rof_dist.sv =====
// module: two-stage squared distance and radius compare
`timescale 1ns / 1ps

module rof_dist (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pt_valid,
  input  rof_pkg::point_t           pt,
  input  rof_pkg::point_t           query,
  input  logic [rof_pkg::SQ_W-1:0]  radius_sq,
  output logic                      hit_valid,
  output logic                      hit,
  output logic                      busy
);
  import rof_pkg::*;

  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W:0]        ax, ay, az;
  logic [SQ_W-1:0]         sqx_r, sqy_r, sqz_r;
  logic                    sq_valid_r;
  logic [DIST_W-1:0]       dist_sq;
  logic                    hit_r, hit_valid_r;

  // signed difference, magnitude fits in COORD_W bits
  assign dx = $signed({pt.x[COORD_W-1], pt.x}) - $signed({query.x[COORD_W-1], query.x});
  assign dy = $signed({pt.y[COORD_W-1], pt.y}) - $signed({query.y[COORD_W-1], query.y});
  assign dz = $signed({pt.z[COORD_W-1], pt.z}) - $signed({query.z[COORD_W-1], query.z});
  assign ax = dx[COORD_W] ? (~dx + 1'b1) : dx;
  assign ay = dy[COORD_W] ? (~dy + 1'b1) : dy;
  assign az = dz[COORD_W] ? (~dz + 1'b1) : dz;

  // stage 1: squares
  always_ff @(posedge clk) begin
    sqx_r <= SQ_W'(ax[COORD_W-1:0]) * SQ_W'(ax[COORD_W-1:0]);
    sqy_r <= SQ_W'(ay[COORD_W-1:0]) * SQ_W'(ay[COORD_W-1:0]);
    sqz_r <= SQ_W'(az[COORD_W-1:0]) * SQ_W'(az[COORD_W-1:0]);
  end

  // stage 2: sum and compare, boundary counts
  assign dist_sq = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);

  always_ff @(posedge clk) begin
    hit_r <= (dist_sq <= DIST_W'(radius_sq));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
      hit_valid_r <= 1'b0;
    end else begin
      sq_valid_r <= pt_valid;
      hit_valid_r <= sq_valid_r;
    end
  end

  assign hit_valid = hit_valid_r;
  assign hit = hit_r;
  assign busy = sq_valid_r | hit_valid_r;

endmodule

// ===== rtl/radius_outlier_filter.sv =====
// module: top level of the radius outlier filter with point store and sweep sequencer
`timescale 1ns / 1ps
// clear, append, bad index: result registered, then parked in the output register by emit
// valid evaluate: query fetch, a sweep of one store read per cycle, then a pipeline drain
// throughput: one transaction in flight; the next input is taken once the result is parked
// reset: registers go to their defaults and the point count to zero; no clearing pass,
// store entries hold garbage until appended and only entries below the count are read

module radius_outlier_filter #(
  parameter int MAX_POINTS = rof_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rof_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [rof_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [rof_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [rof_pkg::COORD_W-1:0]  in_pos_z,
  input  logic [rof_pkg::INDEX_W-1:0]         in_point_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rof_pkg::STATUS_W-1:0]        out_status,
  output logic signed [rof_pkg::COORD_W-1:0]  out_x,
  output logic signed [rof_pkg::COORD_W-1:0]  out_y,
  output logic signed [rof_pkg::COORD_W-1:0]  out_z,
  output logic [rof_pkg::NBCNT_W-1:0]         out_neighbor_count,
  output logic                                out_keep,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import rof_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRD   = 3'd1;
  localparam logic [2:0] S_QLAT  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]          state_r, state_nxt;

  // configuration registers
  logic [RADIUS_W-1:0] radius_r;
  logic [NBCNT_W-1:0]  min_nb_r;
  logic                cfg_wr;

  // point store, one write and one registered read port
  point_t              mem [MAX_POINTS];
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  point_t              rd_data_r;
  logic                rd_valid_r;

  logic [CW-1:0]       count_r;
  logic [AW-1:0]       qaddr_r;
  logic [AW-1:0]       k_r;
  point_t              query_r;
  logic [SQ_W-1:0]     radius_sq_r;
  logic [CW-1:0]       nb_r;

  result_t             res_r, res_nxt;
  result_t             out_res_r;
  logic                out_valid_r;

  logic                in_fire;
  logic                store_full;
  logic                bad_index;
  logic [AW+INDEX_W-1:0] qwide;
  logic                sweep_last;
  logic                hit_valid, hit, dist_busy;
  logic [CW+NBCNT_W-1:0] nb_ext;
  logic [NBCNT_W-1:0]  nb_sat;
  logic                nb_keep;

  // ---------------------------------------------------------------------------
  // configuration port, no wait states; register picked by paddr bit 2
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      min_nb_r <= MIN_NB_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_RADIUS: radius_r <= cfg_pwdata[RADIUS_W-1:0];
        REG_MIN_NB: min_nb_r <= cfg_pwdata[NBCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_RADIUS: cfg_prdata = {{(32-RADIUS_W){1'b0}}, radius_r};
      REG_MIN_NB: cfg_prdata = {{(32-NBCNT_W){1'b0}}, min_nb_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid & in_ready;
  assign store_full = (count_r >= CW'(MAX_POINTS));
  // index past the fill level; the fill level never exceeds the depth
  assign bad_index = ({{CW{1'b0}}, in_point_index} >= {{INDEX_W{1'b0}}, count_r});
  assign qwide = {{AW{1'b0}}, in_point_index};

  // append writes at the accept edge; evaluate reads only start in the S_QRD state after it,
  // so no read can meet a write to the same entry
  assign mem_we = in_fire && (in_func == FUNC_APPEND) && !store_full;
  assign mem_waddr = count_r[AW-1:0];
  assign mem_raddr = (state_r == S_QRD) ? qaddr_r : k_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
    end
    rd_data_r <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // sweep sequencer
  // ---------------------------------------------------------------------------
  assign sweep_last = ((CW'(k_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_CLEAR || in_func == FUNC_APPEND) begin
            state_nxt = S_EMIT;
          end else if (in_func == FUNC_EVAL) begin
            state_nxt = bad_index ? S_EMIT : S_QRD;
          end
        end
      end
      S_QRD:   state_nxt = S_QLAT;
      S_QLAT:  state_nxt = S_SWEEP;
      S_SWEEP: if (sweep_last) state_nxt = S_DRAIN;
      S_DRAIN: if (!rd_valid_r && !dist_busy) state_nxt = S_EMIT;
      S_EMIT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_valid_r <= (state_r == S_SWEEP);
      if (in_fire && in_func == FUNC_CLEAR) begin
        count_r <= '0;
      end else if (mem_we) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // query fetch, radius square and neighbor accumulation
  always_ff @(posedge clk) begin
    if (in_fire) begin
      qaddr_r <= qwide[AW-1:0];
    end
    if (state_r == S_QRD) begin
      radius_sq_r <= SQ_W'(radius_r) * SQ_W'(radius_r);
    end
    if (state_r == S_QLAT) begin
      query_r <= rd_data_r;
      k_r <= '0;
      nb_r <= '0;
    end else begin
      if (state_r == S_SWEEP) begin
        k_r <= k_r + AW'(1);
      end
      if (hit_valid && hit) begin
        nb_r <= nb_r + CW'(1);
      end
    end
  end

  rof_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (rd_valid_r),
    .pt        (rd_data_r),
    .query     (query_r),
    .radius_sq (radius_sq_r),
    .hit_valid (hit_valid),
    .hit       (hit),
    .busy      (dist_busy)
  );

  // count field saturates, keep uses the full count
  assign nb_ext = {{NBCNT_W{1'b0}}, nb_r};
  assign nb_sat = (nb_ext > (CW+NBCNT_W)'(NBCNT_SAT)) ? NBCNT_SAT : nb_ext[NBCNT_W-1:0];
  assign nb_keep = (nb_ext > {{CW{1'b0}}, min_nb_r});

  // ---------------------------------------------------------------------------
  // pending result and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    res_nxt = res_r;
    if (in_fire) begin
      res_nxt = '0;
      case (in_func)
        FUNC_CLEAR:  res_nxt.status = ST_CLEARED;
        FUNC_APPEND: res_nxt.status = store_full ? ST_FULL : ST_APPENDED;
        default:     res_nxt.status = ST_BAD_INDEX;
      endcase
    end else if (state_r == S_DRAIN) begin
      res_nxt.status = ST_EVALUATED;
      res_nxt.pt = query_r;
      res_nxt.count = nb_sat;
      res_nxt.keep = nb_keep;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && (!out_valid_r || out_ready)) begin
      out_res_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_res_r.status;
  assign out_x = out_res_r.pt.x;
  assign out_y = out_res_r.pt.y;
  assign out_z = out_res_r.pt.z;
  assign out_neighbor_count = out_res_r.count;
  assign out_keep = out_res_r.keep;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("fill count beyond store depth");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (CW'(k_r) < count_r))
    else $error("sweep address past fill level");

  a_self_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_EVALUATED) |-> (out_res_r.count != '0))
    else $error("evaluated point did not count itself");

  a_keep_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.keep) |-> (out_res_r.status == ST_EVALUATED))
    else $error("keep set on a non-evaluate result");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_ready)) |=> out_valid_r && in_ready)
    else $error("result not parked on leaving emit");

endmodule

// ===== dv/radius_outlier_filter_tb.sv =====
// testbench: self-checking test of the radius outlier filter against a built-in point store model
`timescale 1ns / 1ps

module radius_outlier_filter_tb;
  import rof_pkg::*;

  localparam int STORE_DEPTH = MAX_POINTS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;  // reserved code, block ignores it
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 16;    // covers an ignored transaction still in flight
  localparam int DRAIN_CYCLES = 64;     // quiet time at the end to catch stray results
  localparam int HOLDOFF_CYCLES = 400;  // long result stall, fills the block
  localparam int MAX_REPORTS = 30;
  localparam int PHASE_ITEMS = 145;
  localparam bit FIXED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    point_t             p;
    logic [INDEX_W-1:0] idx;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic signed [COORD_W-1:0] in_pos_x = '0;
  logic signed [COORD_W-1:0] in_pos_y = '0;
  logic signed [COORD_W-1:0] in_pos_z = '0;
  logic [INDEX_W-1:0] in_point_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [NBCNT_W-1:0] out_neighbor_count;
  logic out_keep;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // shadow of the block: registers and the point store
  logic [RADIUS_W-1:0] cfg_radius = RADIUS_RST;
  logic [NBCNT_W-1:0] cfg_min_nb = MIN_NB_RST;
  point_t stored_pts [STORE_DEPTH];
  int stored_count = 0;

  // results still owed by the block, oldest first
  result_t awaited_results[$];

  // directed stimulus table
  stim_row_t directed_rows[$];

  // flow control knobs
  int gap_pct = 0;
  int stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  // bookkeeping
  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int evals_seen = 0;
  int kept_seen = 0;
  int bad_index_seen = 0;
  int full_seen = 0;

  radius_outlier_filter #(
    .MAX_POINTS(STORE_DEPTH)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_point_index     (in_point_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_z              (out_z),
    .out_neighbor_count (out_neighbor_count),
    .out_keep           (out_keep),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // point store model: one call per accepted transaction, returns what the block
  // must answer; produces is low for the reserved function code
  // ---------------------------------------------------------------------------
  function automatic result_t predict_outcome(input logic [FUNC_W-1:0] f, input point_t p,
                                              input logic [INDEX_W-1:0] idx,
                                              output bit produces);
    result_t r;
    point_t q;
    longint r2;
    longint dx;
    longint dy;
    longint dz;
    int hits;
    int k;
    r = '0;
    produces = 1'b1;
    hits = 0;
    case (f)
      FUNC_CLEAR: begin
        stored_count = 0;
        r.status = ST_CLEARED;
      end
      FUNC_APPEND: begin
        if (stored_count >= STORE_DEPTH) begin
          r.status = ST_FULL;  // point dropped, count unchanged
        end else begin
          stored_pts[stored_count] = p;
          stored_count++;
          r.status = ST_APPENDED;
        end
      end
      FUNC_EVAL: begin
        if (int'(idx) >= stored_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          // exact squared distances, up to 34 bits, so 64-bit math
          q = stored_pts[idx];
          r2 = longint'(cfg_radius) * longint'(cfg_radius);
          for (k = 0; k < stored_count; k++) begin
            dx = longint'(stored_pts[k].x) - longint'(q.x);
            dy = longint'(stored_pts[k].y) - longint'(q.y);
            dz = longint'(stored_pts[k].z) - longint'(q.z);
            if (dx * dx + dy * dy + dz * dz <= r2) hits++;  // boundary counts
          end
          r.status = ST_EVALUATED;
          r.pt = q;
          r.count = (hits > int'(NBCNT_SAT)) ? NBCNT_SAT : hits[NBCNT_W-1:0];
          r.keep = (hits > int'(cfg_min_nb));
        end
      end
      default: produces = 1'b0;
    endcase
    return r;
  endfunction

  function automatic result_t status_only(input logic [STATUS_W-1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [FUNC_W-1:0] f, input int x, input int y,
                                    input int z, input int idx, input bit typed,
                                    input result_t want);
    stim_row_t r;
    r.func = f;
    r.p.x = x[COORD_W-1:0];
    r.p.y = y[COORD_W-1:0];
    r.p.z = z[COORD_W-1:0];
    r.idx = idx[INDEX_W-1:0];
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // append one row at the end of the directed table
  function automatic void add_row(input stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[COORD_W-1:0];
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one transaction per call, random idle gaps before it, valid held
  // high until accepted; the expectation is queued at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic issue(input logic [FUNC_W-1:0] f, input point_t p,
                       input logic [INDEX_W-1:0] idx, input bit typed, input result_t want);
    result_t predicted;
    bit produces;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_pos_x <= p.x;
    in_pos_y <= p.y;
    in_pos_z <= p.z;
    in_point_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_outcome(f, p, idx, produces);
    if (produces) awaited_results.insert(awaited_results.size(), typed ? want : predicted);
    items_sent++;
  endtask

  // drop valid and sit until the block owes nothing; always moves at least one edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // register write followed by a read back, only called with the block idle
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] held;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // setup then access phase of the write
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_RADIUS) cfg_radius = val[RADIUS_W-1:0];
    else cfg_min_nb = val[NBCNT_W-1:0];
    held = (idx == REG_RADIUS) ? {16'b0, cfg_radius} : {21'b0, cfg_min_nb};
    // back-to-back read of the same register
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field((idx == REG_RADIUS) ? "radius_mm readback" : "min_neighbor_count readback",
                held, cfg_prdata);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: clouds of points around a center, spread on the scale of the
  // radius so counts vary; evaluations mostly hit stored points, with some noise
  // ---------------------------------------------------------------------------
  task automatic random_phase(input int n_items);
    int done;
    int roll;
    int spread;
    point_t p;
    point_t center;
    logic [INDEX_W-1:0] idx;
    done = 0;
    center = {16'($urandom), 16'($urandom), 16'($urandom)};
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      p = {16'($urandom), 16'($urandom), 16'($urandom)};
      idx = INDEX_W'($urandom);
      spread = int'(cfg_radius) + 1;
      if (roll < 4) begin
        // reserved code: ignored by the block, not counted
        issue(FUNC_UNUSED, p, idx, PREDICTED, '0);
        continue;
      end
      if (done == n_items / 2) wait_drained();  // sender pause mid-phase
      if (roll < 9 || stored_count >= 64) begin
        issue(FUNC_CLEAR, p, idx, PREDICTED, '0);
        center = {16'($urandom), 16'($urandom), 16'($urandom)};
      end else if (roll < 55 || stored_count == 0) begin
        if (roll % 10 != 0) begin
          p.x = clamp_coord(int'(center.x) + int'($urandom_range(0, 2 * spread)) - spread);
          p.y = clamp_coord(int'(center.y) + int'($urandom_range(0, 2 * spread)) - spread);
          p.z = clamp_coord(int'(center.z) + int'($urandom_range(0, 2 * spread)) - spread);
        end
        issue(FUNC_APPEND, p, idx, PREDICTED, '0);
      end else if (roll < 93) begin
        idx = INDEX_W'($urandom_range(0, stored_count - 1));
        issue(FUNC_EVAL, p, idx, PREDICTED, '0);
      end else begin
        // any index, mostly beyond the stored points
        issue(FUNC_EVAL, p, idx, PREDICTED, '0);
      end
      done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready pattern per phase, plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.status = out_status;
      got.pt = {out_x, out_y, out_z};
      got.count = out_neighbor_count;
      got.keep = out_keep;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: result with none expected, status %0d", $time, got.status);
      end else begin
        want = awaited_results.pop_front();
        results_seen++;
        if ($isunknown(got)) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t ns: unknown bits in result, expected %h, got %h", $time, want, got);
        end else begin
          check_field("status", want.status, got.status);
          check_field("out_x", want.pt.x, got.pt.x);
          check_field("out_y", want.pt.y, got.pt.y);
          check_field("out_z", want.pt.z, got.pt.z);
          check_field("neighbor_count", want.count, got.count);
          check_field("keep", want.keep, got.keep);
        end
        case (got.status)
          ST_EVALUATED: begin
            evals_seen++;
            if (got.keep) kept_seen++;
          end
          ST_BAD_INDEX: bad_index_seen++;
          ST_FULL: full_seen++;
          default: ;
        endcase
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    point_t p;
    int phase;
    int gaps [4];
    int stalls [4];
    int i;
    gaps = '{0, 60, 0, 30};
    stalls = '{0, 0, 60, 30};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults (radius 200, minimum 3), boundary and extreme coordinates
    add_row(row(FUNC_EVAL, 0, 0, 0, 0, FIXED, status_only(ST_BAD_INDEX)));
    add_row(row(FUNC_UNUSED, 0, 0, 0, 0, PREDICTED, '0));
    add_row(row(FUNC_CLEAR, 0, 0, 0, 0, FIXED, status_only(ST_CLEARED)));
    add_row(row(FUNC_APPEND, 0, 0, 0, 0, FIXED, status_only(ST_APPENDED)));
    add_row(row(FUNC_EVAL, 0, 0, 0, 0, FIXED,
                result_t'{ST_EVALUATED, '0, 11'd1, 1'b0}));
    // exactly on the radius, just inside it diagonally, just outside it
    add_row(row(FUNC_APPEND, 200, 0, 0, 0, FIXED, status_only(ST_APPENDED)));
    add_row(row(FUNC_APPEND, 0, -200, 0, 0, FIXED, status_only(ST_APPENDED)));
    add_row(row(FUNC_APPEND, 115, 115, 115, 0, FIXED, status_only(ST_APPENDED)));
    add_row(row(FUNC_APPEND, 201, 0, 0, 0, FIXED, status_only(ST_APPENDED)));
    add_row(row(FUNC_EVAL, 0, 0, 0, 0, PREDICTED, '0));
    add_row(row(FUNC_EVAL, 0, 0, 0, 4, PREDICTED, '0));
    // index equal to the count and the largest index
    add_row(row(FUNC_EVAL, 0, 0, 0, 5, FIXED, status_only(ST_BAD_INDEX)));
    add_row(row(FUNC_EVAL, 0, 0, 0, 1023, FIXED, status_only(ST_BAD_INDEX)));
    // coordinate extremes, widest possible distances
    add_row(row(FUNC_APPEND, -32768, -32768, -32768, 1023, FIXED,
                status_only(ST_APPENDED)));
    add_row(row(FUNC_APPEND, 32767, 32767, 32767, 0, FIXED, status_only(ST_APPENDED)));
    add_row(row(FUNC_EVAL, 0, 0, 0, 5, PREDICTED, '0));
    add_row(row(FUNC_EVAL, -1, -1, -1, 6, PREDICTED, '0));
    add_row(row(FUNC_UNUSED, 21845, -21846, -1, 682, PREDICTED, '0));
    add_row(row(FUNC_APPEND, -1, 21845, -21846, 341, FIXED, status_only(ST_APPENDED)));
    add_row(row(FUNC_EVAL, 0, 0, 0, 7, PREDICTED, '0));
    add_row(row(FUNC_CLEAR, 0, 0, 0, 0, FIXED, status_only(ST_CLEARED)));
    add_row(row(FUNC_EVAL, 0, 0, 0, 0, FIXED, status_only(ST_BAD_INDEX)));
    foreach (directed_rows[i])
      issue(directed_rows[i].func, directed_rows[i].p, directed_rows[i].idx,
            directed_rows[i].typed, directed_rows[i].want);

    // full store: widest radius covers the whole grid, so every point sees all 1024
    write_reg(REG_RADIUS, 32'd65535);
    write_reg(REG_MIN_NB, 32'd1023);
    for (i = 0; i < STORE_DEPTH; i++) begin
      p.x = 16'(int'($urandom_range(0, 7)) * 1500 - 5000);
      p.y = 16'(int'($urandom_range(0, 7)) * 1500 - 5000);
      p.z = 16'(int'($urandom_range(0, 7)) * 1500 - 5000);
      issue(FUNC_APPEND, p, 10'($urandom), PREDICTED, '0);
    end
    p = '0;
    issue(FUNC_APPEND, p, '0, FIXED, status_only(ST_FULL));
    issue(FUNC_EVAL, p, 10'd1023, PREDICTED, '0);
    issue(FUNC_EVAL, p, 10'd0, PREDICTED, '0);
    // minimum of 1024: a full neighborhood no longer exceeds it
    write_reg(REG_MIN_NB, 32'd1024);
    issue(FUNC_EVAL, p, 10'd512, PREDICTED, '0);
    // zero radius: only duplicates of the point count
    write_reg(REG_RADIUS, 32'd0);
    write_reg(REG_MIN_NB, 32'd0);
    issue(FUNC_EVAL, p, 10'd1023, PREDICTED, '0);
    issue(FUNC_EVAL, p, 10'd7, PREDICTED, '0);
    issue(FUNC_CLEAR, p, '0, FIXED, status_only(ST_CLEARED));

    // random phases, each with its own settings and idle mix
    for (phase = 0; phase < 4; phase++) begin
      write_reg(REG_RADIUS, $urandom_range(50, 3000));
      write_reg(REG_MIN_NB, $urandom_range(0, 8));
      gap_pct = gaps[phase];
      stall_pct <= stalls[phase];
      // first phase opens with the long result stall while input keeps coming
      if (phase == 0) holdoff_req <= holdoff_req + 1;
      random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d transactions sent, %0d results checked in %0d cycles", items_sent,
             results_seen, cycle_count);
    $display("tb: %0d evaluations (%0d kept), %0d out of range, %0d dropped on full store",
             evals_seen, kept_seen, bad_index_seen, full_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
